@@ rtl/spq_pkg.sv @@
`timescale 1ns / 1ps
package spq_pkg;

   localparam int CAPACITY  = 32;
   localparam int TAG_BITS  = 16;
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int IDX_W     = $clog2(CAPACITY);
   localparam int FUNC_W    = 2;
   localparam int IN_TAG_W  = 16;
   localparam int SEV_W     = 3;
   localparam int STATUS_W  = 3;
   localparam int OUT_TAG_W = 16;
   localparam int OCC_W     = 6;

   localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SERVE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_LIST   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_SERVED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_LISTED   = 3'd4;

   typedef enum logic [1:0] {
      CMD_INSERT,
      CMD_SERVE,
      CMD_LIST
   } cmd_op_type;

   typedef enum logic {
      BK_IDLE,
      BK_LIST
   } back_state_type;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [IN_TAG_W-1:0] entry_tag;
      logic [SEV_W-1:0]    severity;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [OUT_TAG_W-1:0] out_tag;
      logic [SEV_W-1:0]     out_severity;
      logic [OCC_W-1:0]     occupancy;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      cmd_op_type          op;
      logic [TAG_BITS-1:0] tag;
      logic [SEV_W-1:0]    sev;
   } cmd_type;

   // front -> back command channel
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_chan_type;

endpackage

@@ rtl/spq_front.sv @@
`timescale 1ns / 1ps
module spq_front import spq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  req_type      req_data,
   output logic         req_full,
   output cmd_chan_type cmd_chan,
   input  logic         cmd_pop
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       known;
   logic       wr;
   logic       rd;
   cmd_type    dec;

   // classify the request; unused code is accepted and dropped here
   always_comb begin
      dec.tag = TAG_BITS'(req_data.entry_tag);
      dec.sev = req_data.severity;
      known   = 1'b1;
      unique case (req_data.func)
         FUNC_INSERT: dec.op = CMD_INSERT;
         FUNC_SERVE:  dec.op = CMD_SERVE;
         FUNC_LIST:   dec.op = CMD_LIST;
         default: begin
            dec.op = CMD_INSERT;
            known  = 1'b0;
         end
      endcase
   end

   assign req_full = (cnt_ff == 2'd2);
   assign wr       = req_push && !req_full && known;
   assign rd       = cmd_pop && (cnt_ff != 2'd0);

   assign cmd_chan.valid = (cnt_ff != 2'd0);
   assign cmd_chan.cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = rd ? !rd_ptr_ff : rd_ptr_ff;
      unique case ({wr, rd})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         slot_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

@@ rtl/spq_back.sv @@
`timescale 1ns / 1ps
module spq_back import spq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cmd_chan_type cmd_chan,
   output logic         cmd_pop,
   input  logic         rsp_full,
   output logic         rsp_push,
   output rsp_type      rsp
);

   logic [TAG_BITS-1:0] tag_ff [CAPACITY];
   logic [TAG_BITS-1:0] tag_in [CAPACITY];
   logic [SEV_W-1:0]    sev_ff [CAPACITY];
   logic [SEV_W-1:0]    sev_in [CAPACITY];
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   back_state_type      state_ff, state_in;

   logic [CAPACITY-1:0] le;
   logic                is_full;
   logic                is_empty;
   logic                go;
   logic                do_insert;
   logic                do_serve;
   logic                list_end;

   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);
   assign go       = (state_ff == BK_IDLE) && cmd_chan.valid && !rsp_full;
   assign do_insert = go && (cmd_chan.cmd.op == CMD_INSERT) && !is_full;
   assign do_serve  = go && (cmd_chan.cmd.op == CMD_SERVE) && !is_empty;
   assign list_end  = (CNT_W'(idx_ff) == count_ff - CNT_W'(1));

   // le is a thermometer: stored entries that stay ahead of the new one
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      assign le[g] = (CNT_W'(g) < count_ff) && (sev_ff[g] <= cmd_chan.cmd.sev);

      if (g == 0) begin : g_head
         always_comb begin
            tag_in[g] = tag_ff[g];
            sev_in[g] = sev_ff[g];
            if (do_insert && !le[g]) begin
               tag_in[g] = cmd_chan.cmd.tag;
               sev_in[g] = cmd_chan.cmd.sev;
            end else if (do_serve) begin
               tag_in[g] = tag_ff[g+1];
               sev_in[g] = sev_ff[g+1];
            end
         end
      end else if (g == CAPACITY - 1) begin : g_tail
         always_comb begin
            tag_in[g] = tag_ff[g];
            sev_in[g] = sev_ff[g];
            if (do_insert && !le[g]) begin
               tag_in[g] = le[g-1] ? cmd_chan.cmd.tag : tag_ff[g-1];
               sev_in[g] = le[g-1] ? cmd_chan.cmd.sev : sev_ff[g-1];
            end
         end
      end else begin : g_mid
         always_comb begin
            tag_in[g] = tag_ff[g];
            sev_in[g] = sev_ff[g];
            if (do_insert && !le[g]) begin
               tag_in[g] = le[g-1] ? cmd_chan.cmd.tag : tag_ff[g-1];
               sev_in[g] = le[g-1] ? cmd_chan.cmd.sev : sev_ff[g-1];
            end else if (do_serve) begin
               tag_in[g] = tag_ff[g+1];
               sev_in[g] = sev_ff[g+1];
            end
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      if (do_insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_serve) begin
         count_in = count_ff - CNT_W'(1);
      end
      unique case (state_ff)
         BK_IDLE: begin
            if (go && (cmd_chan.cmd.op == CMD_LIST) && (count_ff > CNT_W'(1))) begin
               state_in = BK_LIST;
               idx_in   = IDX_W'(1);
            end
         end
         BK_LIST: begin
            if (!rsp_full) begin
               idx_in = IDX_W'(idx_ff + 1'b1);
               if (list_end) begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd_pop  = 1'b0;
      rsp_push = 1'b0;
      rsp      = '0;
      unique case (state_ff)
         BK_IDLE: begin
            if (go) begin
               cmd_pop       = 1'b1;
               rsp_push      = 1'b1;
               rsp.last      = 1'b1;
               rsp.occupancy = OCC_W'(count_in);
               unique case (cmd_chan.cmd.op)
                  CMD_INSERT: rsp.status = is_full ? ST_DROPPED : ST_INSERTED;
                  CMD_SERVE: begin
                     if (is_empty) begin
                        rsp.status = ST_EMPTY;
                     end else begin
                        rsp.status       = ST_SERVED;
                        rsp.out_tag      = OUT_TAG_W'(tag_ff[0]);
                        rsp.out_severity = sev_ff[0];
                     end
                  end
                  CMD_LIST: begin
                     if (is_empty) begin
                        rsp.status = ST_EMPTY;
                     end else begin
                        rsp.status       = ST_LISTED;
                        rsp.out_tag      = OUT_TAG_W'(tag_ff[0]);
                        rsp.out_severity = sev_ff[0];
                        rsp.last         = (count_ff == CNT_W'(1));
                     end
                  end
                  default: rsp.status = ST_EMPTY;
               endcase
            end
         end
         BK_LIST: begin
            if (!rsp_full) begin
               rsp_push         = 1'b1;
               rsp.status       = ST_LISTED;
               rsp.out_tag      = OUT_TAG_W'(tag_ff[idx_ff]);
               rsp.out_severity = sev_ff[idx_ff];
               rsp.occupancy    = OCC_W'(count_ff);
               rsp.last         = list_end;
            end
         end
         default: rsp = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
      sev_ff <= sev_in;
   end

endmodule

@@ rtl/spq_rsp_queue.sv @@
`timescale 1ns / 1ps
module spq_rsp_queue import spq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   rsp_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       wr;
   logic       rd;

   assign full      = (cnt_ff == 2'd2);
   assign rsp_empty = (cnt_ff == 2'd0);
   assign wr        = push && !full;
   assign rd        = rsp_pop && !rsp_empty;
   assign rsp_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = rd ? !rd_ptr_ff : rd_ptr_ff;
      unique case ({wr, rd})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/stable_priority_queue_top.sv @@
`timescale 1ns / 1ps
// Channel   Ports                        Accepted when
// request   req_push req_full req_data   req_push && !req_full
// response  rsp_pop rsp_empty rsp_data   rsp_pop && !rsp_empty
//
// Insert and serve update the shift-register sorted array directly; list emits
// one entry per cycle while the response queue has room and holds the array.
// A two-entry command queue sits between decode and the array, and a two-entry
// response queue after it. Synchronous active-high reset empties both queues
// and the array (entry payloads are not cleared). A full response queue
// stalls the array; a full command queue raises req_full.
module stable_priority_queue_top import spq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   cmd_chan_type cmd_chan;
   logic         cmd_pop;
   logic         rsp_push;
   logic         rsp_full;
   rsp_type      rsp_next;

   spq_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .cmd_chan (cmd_chan),
      .cmd_pop  (cmd_pop)
   );

   spq_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_chan (cmd_chan),
      .cmd_pop  (cmd_pop),
      .rsp_full (rsp_full),
      .rsp_push (rsp_push),
      .rsp      (rsp_next)
   );

   spq_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_next),
      .full      (rsp_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("response pushed into full queue");

   a_pop_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_chan.valid)
      else $error("command popped from empty queue");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_next.status != ST_LISTED) |-> rsp_next.last)
      else $error("single response without last");

   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> rsp_empty)
      else $error("response queue not empty after reset");
`endif

endmodule
